// File: rtl/mqcs_pkg.sv
// Package for the MQTT client session controller: payload structs, codes and constants.
// No dependencies.
`default_nettype none
package mqcs_pkg;

    typedef enum logic [2:0] {
        KIND_POLL    = 3'd0,
        KIND_CONNECT = 3'd1,
        KIND_SEND    = 3'd2,
        KIND_BYTE    = 3'd3,
        KIND_RXFAIL  = 3'd4,
        KIND_ENQUEUE = 3'd5,
        KIND_BAD6    = 3'd6,
        KIND_BAD7    = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_OPEN    = 3'd1,
        ACT_CONNECT = 3'd2,
        ACT_QUEUE   = 3'd3,
        ACT_PING    = 3'd4,
        ACT_READ    = 3'd5,
        ACT_CLOSE   = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_PARAM     = 3'd1,
        ST_STATE     = 3'd2,
        ST_NOT_READY = 3'd3,
        ST_TIMEOUT   = 3'd4,
        ST_INVALID   = 3'd5,
        ST_IO        = 3'd6,
        ST_NO_SPACE  = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        MODE_DISC      = 2'd0,
        MODE_SENDING   = 2'd1,
        MODE_WAITING   = 2'd2,
        MODE_CONNECTED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        FL_NONE    = 2'd0,
        FL_CONNECT = 2'd1,
        FL_PING    = 2'd2,
        FL_QUEUE   = 2'd3
    } flight_t;

    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_KEEPALIVE = 3'd1;
    localparam logic [2:0] REG_TIMEOUT   = 3'd2;
    localparam logic [2:0] REG_BO_INIT   = 3'd3;
    localparam logic [2:0] REG_BO_MAX    = 3'd4;

    localparam logic [7:0] PINGRESP_TYPE  = 8'hD0;
    localparam logic [7:0] CONNACK_TYPE   = 8'h20;
    localparam logic [7:0] CONNACK_LEN    = 8'h02;
    localparam logic [7:0] CONNACK_RC_MAX = 8'h05;
    localparam logic [31:0] MS_PER_S      = 32'd1000;
    localparam logic [31:0] HALF_RANGE    = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now_ms;
        logic [31:0] poll_budget;
        logic        ok;
        logic        packet_done;
        logic [7:0]  rx_byte;
        logic        rx_not_ready;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] open_timeout;
        logic [2:0]  status;
        logic [1:0]  session_state;
        logic        connected;
        logic [6:0]  pending;
        logic [31:0] dropped;
    } out_item_t;

    // Classified event handed from the front part to the back part.
    typedef struct packed {
        in_item_t    item;
        logic        budget_zero;
    } ev_t;

    typedef struct packed {
        logic        enable;
        logic [15:0] ka_secs;
        logic [31:0] conn_timeout;
        logic [31:0] backoff_initial_ms;
        logic [31:0] backoff_max_ms;
    } cfg_t;

endpackage
`default_nettype wire

// File: rtl/mqcs_front.sv
// Front part: accepts events, classifies them and holds them in a two-entry queue.
// Depends on mqcs_pkg.
`default_nettype none
module mqcs_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire mqcs_pkg::in_item_t in_item,
    output logic                    ev_valid,
    input  wire logic               ev_take,
    output mqcs_pkg::ev_t           ev
);
    mqcs_pkg::ev_t slot_reg [2];
    logic          rd_reg, wr_reg;
    logic [1:0]    cnt_reg;
    mqcs_pkg::ev_t cls;
    logic          do_push, do_pop;

    always_comb
    begin
        cls.item        = in_item;
        cls.budget_zero = (in_item.poll_budget == 32'd0);
    end

    assign full     = (cnt_reg == 2'd2);
    assign ev_valid = (cnt_reg != 2'd0);
    assign ev       = slot_reg[rd_reg];
    assign do_push  = push && !full;
    assign do_pop   = ev_take && ev_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push) wr_reg <= ~wr_reg;
            if (do_pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("front queue count out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !ev_valid) else $error("event shown while empty");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("front count did not advance");
`endif
endmodule
`default_nettype wire

// File: rtl/mqcs_back.sv
// Back part: session state, timers, backoff and receive checks; one event per cycle while results are taken.
// Depends on mqcs_pkg.
`default_nettype none
module mqcs_back #(
    parameter int QUEUE_SLOTS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                ev_valid,
    output logic                     ev_take,
    input  wire mqcs_pkg::ev_t       ev,
    input  wire mqcs_pkg::cfg_t      cfg,
    output logic                     out_valid,
    input  wire logic                out_take,
    output mqcs_pkg::out_item_t      out_item
);
    mqcs_pkg::mode_t   mode_reg, mode_next;
    mqcs_pkg::flight_t fl_reg, fl_next;
    logic        up_reg, up_next, ping_reg, ping_next;
    logic [1:0]  rxp_reg, rxp_next;
    logic [7:0]  code_reg, code_next;
    logic [31:0] last_reg, last_next, recon_reg, recon_next;
    logic [31:0] bo_reg, bo_next, climit_reg, climit_next, drop_reg, drop_next;
    logic [6:0]  fill_reg, fill_next;
    logic [31:0] ka_reg;
    logic        hold_reg;
    mqcs_pkg::out_item_t res_reg;

    logic [2:0]  act, st;
    logic [31:0] tmo, now, since, d0, dly;
    logic        go, drop, retry, bad;

    // Keepalive in milliseconds is registered off the config; the user writes it only while idle, not enforced here.
    always_ff @(posedge clk)
    begin
        ka_reg <= 32'(cfg.ka_secs) * mqcs_pkg::MS_PER_S;
    end

    assign ev_take = ev_valid && (!hold_reg || out_take);
    assign go      = ev_take;
    assign now     = ev.item.now_ms;
    assign since   = now - last_reg;
    assign d0      = (bo_reg == 32'd0) ? cfg.backoff_initial_ms : bo_reg;
    assign dly     = (d0 < cfg.backoff_max_ms) ?
                     ((d0 > (cfg.backoff_max_ms >> 1)) ? cfg.backoff_max_ms : d0 << 1) : d0;

    always_comb
    begin
        mode_next = mode_reg; fl_next = fl_reg; up_next = up_reg; ping_next = ping_reg;
        rxp_next = rxp_reg; code_next = code_reg; last_next = last_reg;
        recon_next = recon_reg; bo_next = bo_reg; climit_next = climit_reg;
        fill_next = fill_reg; drop_next = drop_reg;
        act = 3'(mqcs_pkg::ACT_NONE); tmo = 32'd0; st = 3'(mqcs_pkg::ST_OK);
        drop = 1'b0; retry = 1'b0; bad = 1'b0;
        unique case (mqcs_pkg::kind_t'(ev.item.kind))
            mqcs_pkg::KIND_POLL:
            begin
                if (ev.budget_zero) st = 3'(mqcs_pkg::ST_PARAM);
                else if (!cfg.enable) st = 3'(mqcs_pkg::ST_STATE);
                else
                begin
                    unique case (mode_reg)
                        mqcs_pkg::MODE_DISC:
                            if ((now - recon_reg) >= mqcs_pkg::HALF_RANGE)
                                st = 3'(mqcs_pkg::ST_NOT_READY);
                            else
                            begin
                                tmo = (cfg.conn_timeout > ev.item.poll_budget) ?
                                      ev.item.poll_budget : cfg.conn_timeout;
                                fl_next = mqcs_pkg::FL_CONNECT;
                                act = 3'(mqcs_pkg::ACT_OPEN);
                            end
                        mqcs_pkg::MODE_SENDING:
                        begin
                            fl_next = mqcs_pkg::FL_CONNECT;
                            act = 3'(mqcs_pkg::ACT_CONNECT);
                        end
                        mqcs_pkg::MODE_WAITING:
                            if ((now - climit_reg) < mqcs_pkg::HALF_RANGE)
                            begin
                                drop = 1'b1; st = 3'(mqcs_pkg::ST_TIMEOUT);
                            end
                            else act = 3'(mqcs_pkg::ACT_READ);
                        mqcs_pkg::MODE_CONNECTED:
                        begin
                            priority if (ping_reg && since >= ka_reg)
                            begin
                                drop = 1'b1; st = 3'(mqcs_pkg::ST_TIMEOUT);
                            end
                            else if (fl_reg == mqcs_pkg::FL_PING) act = 3'(mqcs_pkg::ACT_PING);
                            else if (rxp_reg != 2'd0 || ping_reg) act = 3'(mqcs_pkg::ACT_READ);
                            else if (fill_reg != 7'd0)
                            begin
                                fl_next = mqcs_pkg::FL_QUEUE; act = 3'(mqcs_pkg::ACT_QUEUE);
                            end
                            else if (since >= ka_reg)
                            begin
                                ping_next = 1'b1; fl_next = mqcs_pkg::FL_PING;
                                act = 3'(mqcs_pkg::ACT_PING);
                            end
                            else act = 3'(mqcs_pkg::ACT_READ);
                        end
                    endcase
                end
            end
            mqcs_pkg::KIND_CONNECT:
            begin
                if (mode_reg != mqcs_pkg::MODE_DISC || fl_reg != mqcs_pkg::FL_CONNECT)
                    st = 3'(mqcs_pkg::ST_STATE);
                else if (!ev.item.ok)
                begin
                    fl_next = mqcs_pkg::FL_NONE; up_next = 1'b0; retry = 1'b1;
                    st = 3'(mqcs_pkg::ST_IO);
                end
                else
                begin
                    up_next = 1'b0; mode_next = mqcs_pkg::MODE_SENDING; ping_next = 1'b0;
                    rxp_next = 2'd0; last_next = now;
                end
            end
            mqcs_pkg::KIND_SEND:
            begin
                if (!((mode_reg == mqcs_pkg::MODE_SENDING && fl_reg == mqcs_pkg::FL_CONNECT) ||
                      (mode_reg == mqcs_pkg::MODE_CONNECTED &&
                       (fl_reg == mqcs_pkg::FL_PING || fl_reg == mqcs_pkg::FL_QUEUE))))
                    st = 3'(mqcs_pkg::ST_STATE);
                else if (!ev.item.ok)
                begin
                    drop = 1'b1; st = 3'(mqcs_pkg::ST_IO);
                end
                else
                begin
                    last_next = now;
                    if (ev.item.packet_done)
                    begin
                        if (mode_reg == mqcs_pkg::MODE_SENDING)
                        begin
                            rxp_next = 2'd0; climit_next = now + cfg.conn_timeout;
                            mode_next = mqcs_pkg::MODE_WAITING;
                        end
                        else if (fl_reg == mqcs_pkg::FL_QUEUE && fill_reg != 7'd0)
                            fill_next = fill_reg - 7'd1;
                        fl_next = mqcs_pkg::FL_NONE;
                    end
                end
            end
            mqcs_pkg::KIND_BYTE:
            begin
                if (mode_reg == mqcs_pkg::MODE_WAITING)
                begin
                    unique case (rxp_reg)
                        2'd0: bad = ev.item.rx_byte != mqcs_pkg::CONNACK_TYPE;
                        2'd1: bad = ev.item.rx_byte != mqcs_pkg::CONNACK_LEN;
                        2'd2: bad = ev.item.rx_byte != 8'd0;
                        2'd3: bad = ev.item.rx_byte > mqcs_pkg::CONNACK_RC_MAX;
                    endcase
                    if (bad)
                    begin
                        drop = 1'b1; st = 3'(mqcs_pkg::ST_INVALID);
                    end
                    else if (rxp_reg != 2'd3) rxp_next = rxp_reg + 2'd1;
                    else
                    begin
                        code_next = ev.item.rx_byte; rxp_next = 2'd0;
                        if (ev.item.rx_byte != 8'd0)
                        begin
                            drop = 1'b1; st = 3'(mqcs_pkg::ST_IO);
                        end
                        else
                        begin
                            mode_next = mqcs_pkg::MODE_CONNECTED; up_next = 1'b1;
                            last_next = now; bo_next = cfg.backoff_initial_ms;
                        end
                    end
                end
                else if (mode_reg == mqcs_pkg::MODE_CONNECTED)
                begin
                    bad = (rxp_reg == 2'd0) ? (ev.item.rx_byte != mqcs_pkg::PINGRESP_TYPE)
                                           : (ev.item.rx_byte != 8'd0);
                    if (bad)
                    begin
                        drop = 1'b1; st = 3'(mqcs_pkg::ST_INVALID);
                    end
                    else if (rxp_reg == 2'd0) rxp_next = 2'd1;
                    else
                    begin
                        rxp_next = 2'd0; ping_next = 1'b0; last_next = now;
                    end
                end
                else st = 3'(mqcs_pkg::ST_STATE);
            end
            mqcs_pkg::KIND_RXFAIL:
            begin
                if (mode_reg != mqcs_pkg::MODE_WAITING && mode_reg != mqcs_pkg::MODE_CONNECTED)
                    st = 3'(mqcs_pkg::ST_STATE);
                else if (ev.item.rx_not_ready) st = 3'(mqcs_pkg::ST_NOT_READY);
                else
                begin
                    drop = 1'b1; st = 3'(mqcs_pkg::ST_IO);
                end
            end
            mqcs_pkg::KIND_ENQUEUE:
            begin
                if (fill_reg >= 7'(QUEUE_SLOTS))
                begin
                    if (drop_reg != 32'hFFFF_FFFF) drop_next = drop_reg + 32'd1;
                    st = 3'(mqcs_pkg::ST_NO_SPACE);
                end
                else if (!ev.item.ok) st = 3'(mqcs_pkg::ST_NO_SPACE);
                else fill_next = fill_reg + 7'd1;
            end
            default: st = 3'(mqcs_pkg::ST_PARAM);
        endcase
        if (drop)
        begin
            up_next = 1'b0; mode_next = mqcs_pkg::MODE_DISC; ping_next = 1'b0;
            fl_next = mqcs_pkg::FL_NONE; rxp_next = 2'd0; retry = 1'b1;
            act = 3'(mqcs_pkg::ACT_CLOSE);
        end
        if (retry)
        begin
            recon_next = now + d0; bo_next = dly;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= mqcs_pkg::MODE_DISC; fl_reg <= mqcs_pkg::FL_NONE;
            up_reg <= 1'b0; ping_reg <= 1'b0; rxp_reg <= 2'd0; code_reg <= 8'd0;
            last_reg <= 32'd0; recon_reg <= 32'd0; bo_reg <= 32'd1000;
            climit_reg <= 32'd0; fill_reg <= 7'd0; drop_reg <= 32'd0; hold_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                mode_reg <= mode_next; fl_reg <= fl_next; up_reg <= up_next;
                ping_reg <= ping_next; rxp_reg <= rxp_next; code_reg <= code_next;
                last_reg <= last_next; recon_reg <= recon_next; bo_reg <= bo_next;
                climit_reg <= climit_next; fill_reg <= fill_next; drop_reg <= drop_next;
                hold_reg <= 1'b1;
            end
            else if (out_take) hold_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            res_reg.action <= act; res_reg.open_timeout <= tmo; res_reg.status <= st;
            res_reg.session_state <= mode_next; res_reg.connected <= up_next;
            res_reg.pending <= fill_next; res_reg.dropped <= drop_next;
        end
    end

    assign out_valid = hold_reg;
    assign out_item  = res_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 7'(QUEUE_SLOTS)) else $error("queue fill above slot count");
    a_up_mode: assert property (@(posedge clk) disable iff (!rst_n)
        up_reg |-> mode_reg == mqcs_pkg::MODE_CONNECTED) else $error("up while not connected");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_reg && !out_take) |-> !ev_take) else $error("result overwritten");
    a_drop_mono: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> drop_reg >= $past(drop_reg)) else $error("drop count fell");
`endif
endmodule
`default_nettype wire

// File: rtl/mqtt_client_session_controller.sv
// Top level of the MQTT client session controller: config registers, front and back parts.
// Depends on mqcs_pkg, mqcs_front and mqcs_back.
`default_nettype none
// One event is taken per clock cycle while results are popped: a two-entry event
// queue feeds the session engine, which handles each event as it is taken and holds
// its result in an output register until popped, so one result per cycle is sustained.
// A pushed event passes the event queue slot and then the output register before its
// result appears on the result ports. Configuration is registered on the write, and
// keepalive changes are registered once more.
module mqtt_client_session_controller #(
    parameter int QUEUE_SLOTS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire mqcs_pkg::in_item_t  in_item,
    output logic                     empty,
    input  wire logic                pop,
    output mqcs_pkg::out_item_t      out_item,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);
    mqcs_pkg::cfg_t cfg_reg;
    mqcs_pkg::ev_t  ev;
    logic           ev_valid, ev_take, out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable             <= 1'b0;
            cfg_reg.ka_secs            <= 16'd60;
            cfg_reg.conn_timeout       <= 32'd5000;
            cfg_reg.backoff_initial_ms <= 32'd1000;
            cfg_reg.backoff_max_ms     <= 32'd60000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mqcs_pkg::REG_ENABLE:    cfg_reg.enable             <= cfg_data[0];
                mqcs_pkg::REG_KEEPALIVE: cfg_reg.ka_secs            <= cfg_data[15:0];
                mqcs_pkg::REG_TIMEOUT:   cfg_reg.conn_timeout       <= cfg_data;
                mqcs_pkg::REG_BO_INIT:   cfg_reg.backoff_initial_ms <= cfg_data;
                mqcs_pkg::REG_BO_MAX:    cfg_reg.backoff_max_ms     <= cfg_data;
                default: ;
            endcase
        end
    end

    mqcs_front u_front (
        .clk, .rst_n, .push, .full, .in_item,
        .ev_valid, .ev_take, .ev
    );

    mqcs_back #(.QUEUE_SLOTS(QUEUE_SLOTS)) u_back (
        .clk, .rst_n, .ev_valid, .ev_take, .ev, .cfg(cfg_reg),
        .out_valid, .out_take(pop), .out_item
    );

    assign empty = !out_valid;

`ifndef SYNTHESIS
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty) else $error("result lost before transfer");
    a_ka_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> $stable(cfg_reg)) else $error("config changed without write");
    a_full_back: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> ev_valid) else $error("full with no event waiting");
`endif
endmodule
`default_nettype wire

// File: tb/tb_mqtt_client_session_controller.sv
// Self-checking testbench for the MQTT client session controller.
// Depends on mqcs_pkg and the mqtt_client_session_controller RTL.
`timescale 1ns / 100ps
module tb_mqtt_client_session_controller;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    mqcs_pkg::in_item_t  in_item;
    logic                empty;
    logic                pop;
    mqcs_pkg::out_item_t out_item;
    logic                cfg_we;
    logic [2:0]          cfg_index;
    logic [31:0]         cfg_data;

    mqtt_client_session_controller #(.QUEUE_SLOTS(16)) u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam int SLOTS = 16;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Session shadow state.
    logic              m_enable;
    logic [15:0]       m_keepalive;
    logic [31:0]       m_timeout, m_bo_init, m_bo_max;
    mqcs_pkg::mode_t   m_mode;
    logic              m_up, m_ping;
    mqcs_pkg::flight_t m_flight;
    logic [1:0]        m_rxpos;
    logic [31:0]       m_last, m_retry_at, m_delay, m_connack_limit, m_drops;
    logic [6:0]        m_fill;

    mqcs_pkg::in_item_t  event_queue[$];
    mqcs_pkg::out_item_t expected_results[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_off_cycles;
    bit        failed;

    function automatic bit deadline_hit(logic [31:0] now, logic [31:0] dl);
        logic [31:0] d;
        d = now - dl;
        return d < mqcs_pkg::HALF_RANGE;
    endfunction

    function automatic void schedule_reconnect(logic [31:0] now);
        logic [31:0] d;
        d = m_delay;
        if (d == 32'd0)
            d = m_bo_init;
        m_retry_at = now + d;
        if (d < m_bo_max)
            d = (d > (m_bo_max >> 1)) ? m_bo_max : d << 1;
        m_delay = d;
    endfunction

    function automatic mqcs_pkg::action_t tear_down(logic [31:0] now);
        m_up = 1'b0;
        m_mode = mqcs_pkg::MODE_DISC;
        m_ping = 1'b0;
        m_flight = mqcs_pkg::FL_NONE;
        m_rxpos = 2'd0;
        schedule_reconnect(now);
        return mqcs_pkg::ACT_CLOSE;
    endfunction

    function automatic mqcs_pkg::out_item_t session_next(mqcs_pkg::in_item_t it);
        mqcs_pkg::out_item_t r;
        mqcs_pkg::action_t   act;
        mqcs_pkg::status_t   st;
        logic [31:0] tmo, ka, now;
        bit        bad, conn_a, conn_b;
        act = mqcs_pkg::ACT_NONE;
        st = mqcs_pkg::ST_OK;
        tmo = 32'd0;
        now = it.now_ms;
        case (mqcs_pkg::kind_t'(it.kind))
            mqcs_pkg::KIND_POLL:
            begin
                ka = {16'd0, m_keepalive} * mqcs_pkg::MS_PER_S;
                if (it.poll_budget == 32'd0)
                    st = mqcs_pkg::ST_PARAM;
                else if (!m_enable)
                    st = mqcs_pkg::ST_STATE;
                else if (m_mode == mqcs_pkg::MODE_DISC)
                begin
                    if (!deadline_hit(now, m_retry_at))
                        st = mqcs_pkg::ST_NOT_READY;
                    else
                    begin
                        tmo = (m_timeout > it.poll_budget) ? it.poll_budget : m_timeout;
                        m_flight = mqcs_pkg::FL_CONNECT;
                        act = mqcs_pkg::ACT_OPEN;
                    end
                end
                else if (m_mode == mqcs_pkg::MODE_SENDING)
                begin
                    m_flight = mqcs_pkg::FL_CONNECT;
                    act = mqcs_pkg::ACT_CONNECT;
                end
                else if (m_mode == mqcs_pkg::MODE_WAITING)
                begin
                    if (deadline_hit(now, m_connack_limit))
                    begin
                        act = tear_down(now);
                        st = mqcs_pkg::ST_TIMEOUT;
                    end
                    else
                        act = mqcs_pkg::ACT_READ;
                end
                else if (m_ping && (now - m_last) >= ka)
                begin
                    act = tear_down(now);
                    st = mqcs_pkg::ST_TIMEOUT;
                end
                else if (m_flight == mqcs_pkg::FL_PING)
                    act = mqcs_pkg::ACT_PING;
                else if (m_rxpos > 2'd0 || m_ping)
                    act = mqcs_pkg::ACT_READ;
                else if (m_fill > 7'd0)
                begin
                    m_flight = mqcs_pkg::FL_QUEUE;
                    act = mqcs_pkg::ACT_QUEUE;
                end
                else if ((now - m_last) >= ka)
                begin
                    m_ping = 1'b1;
                    m_flight = mqcs_pkg::FL_PING;
                    act = mqcs_pkg::ACT_PING;
                end
                else
                    act = mqcs_pkg::ACT_READ;
            end
            mqcs_pkg::KIND_CONNECT:
            begin
                if (m_mode != mqcs_pkg::MODE_DISC || m_flight != mqcs_pkg::FL_CONNECT)
                    st = mqcs_pkg::ST_STATE;
                else if (!it.ok)
                begin
                    m_flight = mqcs_pkg::FL_NONE;
                    m_up = 1'b0;
                    schedule_reconnect(now);
                    st = mqcs_pkg::ST_IO;
                end
                else
                begin
                    m_up = 1'b0;
                    m_mode = mqcs_pkg::MODE_SENDING;
                    m_ping = 1'b0;
                    m_rxpos = 2'd0;
                    m_last = now;
                end
            end
            mqcs_pkg::KIND_SEND:
            begin
                conn_a = (m_mode == mqcs_pkg::MODE_SENDING) &&
                         (m_flight == mqcs_pkg::FL_CONNECT);
                conn_b = (m_mode == mqcs_pkg::MODE_CONNECTED) &&
                         (m_flight == mqcs_pkg::FL_PING || m_flight == mqcs_pkg::FL_QUEUE);
                if (!conn_a && !conn_b)
                    st = mqcs_pkg::ST_STATE;
                else if (!it.ok)
                begin
                    act = tear_down(now);
                    st = mqcs_pkg::ST_IO;
                end
                else
                begin
                    m_last = now;
                    if (it.packet_done)
                    begin
                        if (conn_a)
                        begin
                            m_rxpos = 2'd0;
                            m_connack_limit = now + m_timeout;
                            m_mode = mqcs_pkg::MODE_WAITING;
                        end
                        else if (m_flight == mqcs_pkg::FL_QUEUE && m_fill > 7'd0)
                            m_fill--;
                        m_flight = mqcs_pkg::FL_NONE;
                    end
                end
            end
            mqcs_pkg::KIND_BYTE:
            begin
                if (m_mode == mqcs_pkg::MODE_WAITING)
                begin
                    case (m_rxpos)
                        2'd0: bad = it.rx_byte != mqcs_pkg::CONNACK_TYPE;
                        2'd1: bad = it.rx_byte != mqcs_pkg::CONNACK_LEN;
                        2'd2: bad = it.rx_byte != 8'd0;
                        default: bad = it.rx_byte > mqcs_pkg::CONNACK_RC_MAX;
                    endcase
                    if (bad)
                    begin
                        act = tear_down(now);
                        st = mqcs_pkg::ST_INVALID;
                    end
                    else if (m_rxpos < 2'd3)
                        m_rxpos++;
                    else
                    begin
                        m_rxpos = 2'd0;
                        if (it.rx_byte != 8'd0)
                        begin
                            act = tear_down(now);
                            st = mqcs_pkg::ST_IO;
                        end
                        else
                        begin
                            m_mode = mqcs_pkg::MODE_CONNECTED;
                            m_up = 1'b1;
                            m_last = now;
                            m_delay = m_bo_init;
                        end
                    end
                end
                else if (m_mode == mqcs_pkg::MODE_CONNECTED)
                begin
                    bad = (m_rxpos == 2'd0) ? it.rx_byte != mqcs_pkg::PINGRESP_TYPE
                                            : it.rx_byte != 8'd0;
                    if (bad)
                    begin
                        act = tear_down(now);
                        st = mqcs_pkg::ST_INVALID;
                    end
                    else if (m_rxpos == 2'd0)
                        m_rxpos = 2'd1;
                    else
                    begin
                        m_rxpos = 2'd0;
                        m_ping = 1'b0;
                        m_last = now;
                    end
                end
                else
                    st = mqcs_pkg::ST_STATE;
            end
            mqcs_pkg::KIND_RXFAIL:
            begin
                if (m_mode != mqcs_pkg::MODE_WAITING && m_mode != mqcs_pkg::MODE_CONNECTED)
                    st = mqcs_pkg::ST_STATE;
                else if (it.rx_not_ready)
                    st = mqcs_pkg::ST_NOT_READY;
                else
                begin
                    act = tear_down(now);
                    st = mqcs_pkg::ST_IO;
                end
            end
            mqcs_pkg::KIND_ENQUEUE:
            begin
                if (m_fill >= SLOTS)
                begin
                    if (m_drops != 32'hFFFF_FFFF)
                        m_drops++;
                    st = mqcs_pkg::ST_NO_SPACE;
                end
                else if (!it.ok)
                    st = mqcs_pkg::ST_NO_SPACE;
                else
                    m_fill++;
            end
            default: st = mqcs_pkg::ST_PARAM;
        endcase
        r.action = act;
        r.open_timeout = tmo;
        r.status = st;
        r.session_state = m_mode;
        r.connected = m_up;
        r.pending = m_fill;
        r.dropped = m_drops;
        return r;
    endfunction

    // Driver: offers the head of the event queue, honoring the idle percentage.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                expected_results.push_back(session_next(event_queue.pop_front()));
            end
            if (event_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                push <= 1'b1;
                in_item <= event_queue[0];
            end
            else if (!(push && full))
            begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: compares each result transfer with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        mqcs_pkg::out_item_t e;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no expectation waiting");
                    failed = 1'b1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (out_item.action !== e.action)
                    begin
                        $error("action exp %0d got %0d", e.action, out_item.action);
                        failed = 1'b1;
                    end
                    if (out_item.open_timeout !== e.open_timeout)
                    begin
                        $error("open_timeout exp %0d got %0d",
                               e.open_timeout, out_item.open_timeout);
                        failed = 1'b1;
                    end
                    if (out_item.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, out_item.status);
                        failed = 1'b1;
                    end
                    if (out_item.session_state !== e.session_state)
                    begin
                        $error("session_state exp %0d got %0d",
                               e.session_state, out_item.session_state);
                        failed = 1'b1;
                    end
                    if (out_item.connected !== e.connected)
                    begin
                        $error("connected exp %0d got %0d", e.connected, out_item.connected);
                        failed = 1'b1;
                    end
                    if (out_item.pending !== e.pending)
                    begin
                        $error("pending exp %0d got %0d", e.pending, out_item.pending);
                        failed = 1'b1;
                    end
                    if (out_item.dropped !== e.dropped)
                    begin
                        $error("dropped exp %0d got %0d", e.dropped, out_item.dropped);
                        failed = 1'b1;
                    end
                end
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Event time advances slowly, with occasional large jumps to reach deadlines.
    logic [31:0] clock_ms;

    function automatic mqcs_pkg::in_item_t make_event(mqcs_pkg::kind_t k, logic [31:0] budget,
                                                      bit ok, bit done, logic [7:0] b, bit nr);
        mqcs_pkg::in_item_t it;
        it.kind = k;
        it.now_ms = clock_ms;
        it.poll_budget = budget;
        it.ok = ok;
        it.packet_done = done;
        it.rx_byte = b;
        it.rx_not_ready = nr;
        return it;
    endfunction

    task automatic queue_event(mqcs_pkg::kind_t k, logic [31:0] budget, bit ok, bit done,
                               logic [7:0] b, bit nr);
        event_queue.push_back(make_event(k, budget, ok, done, b, nr));
    endtask

    task automatic tick_time();
        case ($urandom_range(9))
            0: clock_ms = clock_ms + $urandom;
            1, 2: clock_ms = clock_ms + $urandom_range(70000);
            default: clock_ms = clock_ms + $urandom_range(50);
        endcase
    endtask

    task automatic random_budget(output logic [31:0] bgt);
        case ($urandom_range(7))
            0: bgt = 32'd0;
            1: bgt = $urandom;
            2: bgt = 32'hFFFF_FFFF;
            default: bgt = $urandom_range(20000, 1);
        endcase
    endtask

    // One well-formed session walk with random faults mixed in.
    task automatic session_walk();
        logic [31:0] bgt;
        int n;
        random_budget(bgt);
        tick_time();
        queue_event(mqcs_pkg::KIND_POLL, bgt == 32'd0 ? 32'd100 : bgt, 1, 1, 8'd0, 0);
        queue_event(mqcs_pkg::KIND_CONNECT, 32'd0, $urandom_range(9) != 0, 1,
                    8'($urandom), 1'($urandom));
        tick_time();
        queue_event(mqcs_pkg::KIND_POLL, $urandom_range(5000, 1), 1, 1, 8'd0, 0);
        queue_event(mqcs_pkg::KIND_SEND, $urandom, $urandom_range(9) != 0,
                    $urandom_range(3) != 0, 8'($urandom), 0);
        tick_time();
        queue_event(mqcs_pkg::KIND_POLL, $urandom_range(5000, 1), 1, 1, 8'd0, 0);
        queue_event(mqcs_pkg::KIND_BYTE, 32'd0, 0, 0,
                    $urandom_range(15) != 0 ? mqcs_pkg::CONNACK_TYPE : 8'($urandom), 0);
        queue_event(mqcs_pkg::KIND_BYTE, 32'd0, 0, 0,
                    $urandom_range(15) != 0 ? mqcs_pkg::CONNACK_LEN : 8'($urandom), 0);
        queue_event(mqcs_pkg::KIND_BYTE, 32'd0, 0, 0,
                    $urandom_range(15) != 0 ? 8'd0 : 8'($urandom), 0);
        queue_event(mqcs_pkg::KIND_BYTE, 32'd0, 0, 0,
                    $urandom_range(3) != 0 ? 8'd0 : 8'($urandom_range(7)), 0);
        n = $urandom_range(20, 4);
        repeat (n)
        begin
            tick_time();
            case ($urandom_range(11))
                0, 1, 2: queue_event(mqcs_pkg::KIND_POLL, $urandom_range(9000, 1), 1, 1,
                                     8'd0, 0);
                3, 4: queue_event(mqcs_pkg::KIND_SEND, 32'd0, $urandom_range(15) != 0,
                                  1'($urandom), 8'd0, 0);
                5, 6: queue_event(mqcs_pkg::KIND_ENQUEUE, 32'd0, $urandom_range(7) != 0, 0,
                                  8'd0, 0);
                7: queue_event(mqcs_pkg::KIND_BYTE, 32'd0, 0, 0,
                               $urandom_range(7) != 0 ? mqcs_pkg::PINGRESP_TYPE
                                                      : 8'($urandom), 0);
                8: queue_event(mqcs_pkg::KIND_BYTE, 32'd0, 0, 0,
                               $urandom_range(7) != 0 ? 8'd0 : 8'($urandom), 0);
                9: queue_event(mqcs_pkg::KIND_RXFAIL, 32'd0, 0, 0, 8'd0,
                               $urandom_range(7) != 0);
                default: queue_event(mqcs_pkg::kind_t'($urandom_range(7)), $urandom,
                                     1'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
            endcase
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mqcs_pkg::REG_ENABLE: m_enable = val[0];
            mqcs_pkg::REG_KEEPALIVE: m_keepalive = val[15:0];
            mqcs_pkg::REG_TIMEOUT: m_timeout = val;
            mqcs_pkg::REG_BO_INIT: m_bo_init = val;
            default: m_bo_max = val;
        endcase
    endtask

    task automatic drain();
        while (event_queue.size() > 0 || push || expected_results.size() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_config(logic en, logic [15:0] ka, logic [31:0] tmo,
                              logic [31:0] bi, logic [31:0] bm);
        write_reg(mqcs_pkg::REG_ENABLE, 32'(en));
        write_reg(mqcs_pkg::REG_KEEPALIVE, 32'(ka));
        write_reg(mqcs_pkg::REG_TIMEOUT, tmo);
        write_reg(mqcs_pkg::REG_BO_INIT, bi);
        write_reg(mqcs_pkg::REG_BO_MAX, bm);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        #20_000_000;
        $display("tb_mqtt_client_session_controller NOT OK");
        $finish;
    end

    initial
    begin
        int phase;
        int k;
        failed = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = mqcs_pkg::REG_ENABLE;
        cfg_data = '0;
        in_item = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        clock_ms = '0;
        m_enable = 1'b0; m_keepalive = 16'd60; m_timeout = 32'd5000; m_bo_init = 32'd1000;
        m_bo_max = 32'd60000; m_mode = mqcs_pkg::MODE_DISC; m_up = 1'b0; m_ping = 1'b0;
        m_flight = mqcs_pkg::FL_NONE;
        m_rxpos = 2'd0; m_last = '0; m_retry_at = '0; m_delay = 32'd1000;
        m_connack_limit = '0;
        m_fill = 7'd0; m_drops = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: disabled and zero-budget polls, stray events, bad kinds, queue overflow.
        queue_event(mqcs_pkg::KIND_POLL, 32'd0, 0, 0, 8'd0, 0);
        queue_event(mqcs_pkg::KIND_POLL, 32'hFFFF_FFFF, 1, 1, 8'hFF, 1);
        queue_event(mqcs_pkg::KIND_CONNECT, 32'd0, 1, 0, 8'd0, 0);
        queue_event(mqcs_pkg::KIND_SEND, 32'd0, 1, 1, 8'd0, 0);
        queue_event(mqcs_pkg::KIND_BYTE, 32'd0, 0, 0, 8'hFF, 0);
        queue_event(mqcs_pkg::KIND_RXFAIL, 32'd0, 0, 0, 8'd0, 1);
        queue_event(mqcs_pkg::KIND_BAD6, 32'd0, 1, 1, 8'd0, 0);
        queue_event(mqcs_pkg::KIND_BAD7, 32'hFFFF_FFFF, 1, 1, 8'hFF, 1);
        for (k = 0; k < SLOTS + 2; k++)
            queue_event(mqcs_pkg::KIND_ENQUEUE, 32'd0, k != 3, 0, 8'd0, 0);
        drain();
        set_config(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        clock_ms = 32'hFFFF_FFF0;
        session_walk();
        drain();
        set_config(1'b1, 16'd1, 32'd1, 32'd1, 32'd1);
        session_walk();
        drain();
        set_config(1'b1, 16'd1, 32'd30, 32'd0, 32'h9000_0000);
        session_walk();
        session_walk();
        drain();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 62; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 62; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            set_config(phase != 5, 16'($urandom_range(3, 1)), $urandom_range(40000, 1),
                       $urandom_range(5000, 1), $urandom_range(3) != 0 ?
                       $urandom_range(90000, 1) : $urandom);
            if (phase == 2)
                hold_off_cycles = 200;
            while (event_queue.size() < 210)
                session_walk();
            // Drain between phases so config writes never meet events in flight.
            drain();
        end
        if (failed)
            $display("tb_mqtt_client_session_controller NOT OK");
        else
            $display("tb_mqtt_client_session_controller OK");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mqcs_pkg.sv
rtl/mqcs_front.sv
rtl/mqcs_back.sv
rtl/mqtt_client_session_controller.sv
tb/tb_mqtt_client_session_controller.sv
